// ===== sv/swr_pkg.sv =====
package swr_pkg;

  localparam int MAX_WORD = 8;
  localparam int CNT_W    = $clog2(MAX_WORD);
  localparam int LEN_W    = $clog2(MAX_WORD + 1);
  localparam int CFG_LEN_W  = 4;
  localparam int CFG_WORD_W = 64;
  localparam int CFG_IDX_W  = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SEARCH_LEN   = 2'd0,
    CFG_REPLACE_LEN  = 2'd1,
    CFG_SEARCH_WORD  = 2'd2,
    CFG_REPLACE_WORD = 2'd3
  } cfg_idx_t;

  // one decision's worth of output bytes, handed to the output sequencer
  typedef struct packed {
    logic                        load;
    logic [LEN_W-1:0]            cnt;
    logic                        last;
    logic                        has;
    logic [MAX_WORD-1:0][7:0]    bytes;
  } burst_t;

  function automatic logic [LEN_W-1:0] eff_search_len(input logic [CFG_LEN_W-1:0] v);
    logic [LEN_W-1:0] r;
    if (v == '0) begin
      r = LEN_W'(1);
    end else if (v > CFG_LEN_W'(MAX_WORD)) begin
      r = LEN_W'(MAX_WORD);
    end else begin
      r = LEN_W'(v);
    end
    return r;
  endfunction

  function automatic logic [LEN_W-1:0] eff_replace_len(input logic [CFG_LEN_W-1:0] v);
    logic [LEN_W-1:0] r;
    if (v > CFG_LEN_W'(MAX_WORD)) begin
      r = LEN_W'(MAX_WORD);
    end else begin
      r = LEN_W'(v);
    end
    return r;
  endfunction

endpackage

// ===== sv/swr_cell.sv =====
module swr_cell
  import swr_pkg::*;
(
  input  logic       clk,
  input  logic       en,
  input  logic       at_tail,
  input  logic       shift,
  input  logic [7:0] in_byte,
  input  logic [7:0] nbr_view,
  input  logic [7:0] search_byte,
  output logic [7:0] view,
  output logic       eq
);

  logic [7:0] held;

  // the incoming byte lands in the cell at the tail of the window
  assign view = at_tail ? in_byte : held;
  assign eq   = (view == search_byte);

  always_ff @(posedge clk) begin
    if (en) begin
      held <= shift ? nbr_view : view;
    end
  end

endmodule

// ===== sv/swr_burst.sv =====
module swr_burst
  import swr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  burst_t     burst,
  output logic       free,
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // out_byte
  output logic       m_tuser,   // has_byte
  output logic       m_tlast
);

  logic [MAX_WORD-1:0][7:0] bytes;
  logic [LEN_W-1:0]         cnt;
  logic                     last;
  logic                     has;
  logic                     move;

  assign move = (cnt != '0) && (!m_tvalid || m_tready);
  assign free = (cnt == '0) || ((cnt == LEN_W'(1)) && move);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (burst.load) begin
        cnt <= burst.cnt;
      end else if (move) begin
        cnt <= cnt - LEN_W'(1);
      end
      if (move) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (burst.load) begin
      bytes <= burst.bytes;
      last  <= burst.last;
      has   <= burst.has;
    end else if (move) begin
      for (int i = 0; i < MAX_WORD - 1; i++) begin
        bytes[i] <= bytes[i+1];
      end
      bytes[MAX_WORD-1] <= '0;
    end
    if (move) begin
      m_tdata <= has ? bytes[0] : 8'h00;
      m_tuser <= has;
      m_tlast <= last && (cnt == LEN_W'(1));
    end
  end

endmodule

// ===== sv/stream_word_replace_core.sv =====
// Streaming find-and-replace over a byte string, one byte per item, tlast on the
// final byte. Each non-overlapping match of search_word (1..8 bytes) is replaced
// by replace_word (0..8 bytes); other bytes pass unchanged, and unmatched bytes
// still in the lookahead window are flushed when the string ends. When the final
// item of a string yields no byte, the string ends with one bare marker (tuser low,
// tdata zero, tlast high). Unless the output stalls, an item yielding at most one
// output byte is taken every cycle; one yielding k > 1 bytes (a replacement or an
// end-of-string flush) holds the input until all but its last byte have left, the
// output sequencer sending one byte per cycle. The window is a row of eight byte
// cells compared in parallel against the search word. Writing search_len drops any
// bytes pending in the window. The user must write configuration only while the
// block is idle, which it does not enforce; no clearing pass is needed after reset.
module stream_word_replace_core
  import swr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_WORD_W-1:0] cfg_data,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [7:0]            s_tdata,   // in_byte
  input  logic                  s_tlast,   // in_last
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [7:0]            m_tdata,   // out_byte
  output logic                  m_tuser,   // has_byte
  output logic                  m_tlast    // out_last
);

  logic [CFG_LEN_W-1:0]     search_len;
  logic [CFG_LEN_W-1:0]     replace_len;
  logic [CFG_WORD_W-1:0]    search_word;
  logic [CFG_WORD_W-1:0]    replace_word;
  logic [CNT_W-1:0]         count;
  logic [CNT_W-1:0]         count_next;

  logic                     accept;
  logic                     free;
  logic [LEN_W-1:0]         slen;
  logic [LEN_W-1:0]         rlen;
  logic [LEN_W-1:0]         fill;
  logic                     full;
  logic                     match;
  logic                     shift;
  logic [MAX_WORD-1:0]      eq;
  logic [MAX_WORD-1:0][7:0] view;
  burst_t                   burst;

  assign s_tready = free;
  assign accept   = s_tvalid && s_tready;
  assign slen     = eff_search_len(search_len);
  assign rlen     = eff_replace_len(replace_len);
  assign fill     = LEN_W'(count) + LEN_W'(1);
  assign full     = (fill == slen);
  assign shift    = full && !match && !s_tlast;

  always_ff @(posedge clk) begin
    if (rst) begin
      search_len   <= CFG_LEN_W'(1);
      replace_len  <= CFG_LEN_W'(1);
      search_word  <= '0;
      replace_word <= '0;
      count        <= '0;
    end else begin
      // a search_len write empties the window
      if (cfg_we && (cfg_index == CFG_SEARCH_LEN)) begin
        count <= '0;
      end else if (accept) begin
        count <= count_next;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_SEARCH_LEN:   search_len   <= cfg_data[CFG_LEN_W-1:0];
          CFG_REPLACE_LEN:  replace_len  <= cfg_data[CFG_LEN_W-1:0];
          CFG_SEARCH_WORD:  search_word  <= cfg_data;
          CFG_REPLACE_WORD: replace_word <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  for (genvar i = 0; i < MAX_WORD; i++) begin : g_cell
    logic [7:0] nbr;
    if (i == MAX_WORD - 1) begin : g_top
      assign nbr = 8'h00;
    end else begin : g_mid
      assign nbr = view[i+1];
    end
    swr_cell u_cell (
      .clk         (clk),
      .en          (accept),
      .at_tail     (count == CNT_W'(i)),
      .shift       (shift),
      .in_byte     (s_tdata),
      .nbr_view    (nbr),
      .search_byte (search_word[8*i +: 8]),
      .view        (view[i]),
      .eq          (eq[i])
    );
  end

  always_comb begin
    match = 1'b1;
    for (int i = 0; i < MAX_WORD; i++) begin
      if ((LEN_W'(i) < slen) && !eq[i]) begin
        match = 1'b0;
      end
    end
  end

  always_comb begin
    burst.load  = accept;
    burst.last  = s_tlast;
    burst.has   = 1'b1;
    burst.bytes = view;
    count_next  = count;
    if (full && match) begin
      burst.bytes = replace_word;
      burst.cnt   = rlen;
      count_next  = '0;
    end else if (full) begin
      burst.cnt   = s_tlast ? slen : LEN_W'(1);
    end else begin
      burst.cnt   = s_tlast ? fill : '0;
      count_next  = CNT_W'(fill);
    end
    if (s_tlast) begin
      count_next = '0;
      // nothing left to send: one bare end marker
      if (burst.cnt == '0) begin
        burst.cnt = LEN_W'(1);
        burst.has = 1'b0;
      end
    end
  end

  swr_burst u_burst (
    .clk      (clk),
    .rst      (rst),
    .burst    (burst),
    .free     (free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

// ===== sv/swr_checker.sv =====
module swr_checker
  import swr_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       s_tready,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic       m_tuser,
  input logic       m_tlast
);

  // a bare marker only ever closes a string
  a_marker_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> m_tlast)
    else $error("bare end marker without tlast");

  a_marker_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> (m_tdata == 8'h00))
    else $error("bare end marker with nonzero data");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
    else $error("stalled output item changed");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!m_tvalid && s_tready))
    else $error("output not empty or input not ready after reset");

endmodule

bind stream_word_replace_core swr_checker u_swr_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
